/* design/mcns_pkg.sv */
// Shared constants, microcode format and microprogram of the common-neighbour suggester.
package mcns_pkg;

  localparam int MAX_NODES  = 64;
  localparam int ID_W       = 6;
  localparam int SUG_W      = 6;
  localparam int TOTAL_W    = 7;
  localparam int ADDR_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W      = $clog2(MAX_NODES + 1);
  localparam int LANES      = (MAX_NODES + 7) / 8;
  localparam int LANE_CNT_W = 4;
  localparam int UPC_W      = 4;

  // microprogram addresses
  localparam logic [UPC_W-1:0] U_CLEAR  = UPC_W'(0);
  localparam logic [UPC_W-1:0] U_IDLE   = UPC_W'(1);
  localparam logic [UPC_W-1:0] U_SETA   = UPC_W'(2);
  localparam logic [UPC_W-1:0] U_SETB   = UPC_W'(3);
  localparam logic [UPC_W-1:0] U_START  = UPC_W'(4);
  localparam logic [UPC_W-1:0] U_ROWI   = UPC_W'(5);
  localparam logic [UPC_W-1:0] U_LATI   = UPC_W'(6);
  localparam logic [UPC_W-1:0] U_ROWJ   = UPC_W'(7);
  localparam logic [UPC_W-1:0] U_POP    = UPC_W'(8);
  localparam logic [UPC_W-1:0] U_SUM    = UPC_W'(9);
  localparam logic [UPC_W-1:0] U_CMP    = UPC_W'(10);
  localparam logic [UPC_W-1:0] U_EMIT   = UPC_W'(11);
  localparam logic [UPC_W-1:0] U_NEXTI  = UPC_W'(12);
  localparam logic [UPC_W-1:0] U_FINISH = UPC_W'(13);

  typedef enum logic [2:0] {
    MEM_NONE  = 3'd0,
    MEM_RD_I  = 3'd1,
    MEM_RD_J  = 3'd2,
    MEM_SET_A = 3'd3,
    MEM_SET_B = 3'd4,
    MEM_CLR   = 3'd5
  } mem_op_t;

  typedef enum logic [3:0] {
    DP_NONE   = 4'd0,
    DP_CLRINC = 4'd1,
    DP_EDGE   = 4'd2,
    DP_I0     = 4'd3,
    DP_J0     = 4'd4,
    DP_LATI   = 4'd5,
    DP_POP    = 4'd6,
    DP_SUM    = 4'd7,
    DP_CMP    = 4'd8,
    DP_EMIT   = 4'd9,
    DP_NEXTI  = 4'd10,
    DP_FINISH = 4'd11
  } dp_op_t;

  typedef enum logic [3:0] {
    C_NEVER    = 4'd0,
    C_ALWAYS   = 4'd1,
    C_NOT_ACC  = 4'd2,
    C_NOT_LAST = 4'd3,
    C_N_ZERO   = 4'd4,
    C_J_MORE   = 4'd5,
    C_I_MORE   = 4'd6,
    C_CLR_MORE = 4'd7,
    C_OUT_BUSY = 4'd8
  } cond_t;

  typedef struct packed {
    logic             take_in;
    mem_op_t          mem_op;
    dp_op_t           dp_op;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } ucw_t;

  function automatic logic [LANE_CNT_W-1:0] popcount8(input logic [7:0] x);
    logic [LANE_CNT_W-1:0] c;
    begin
      c = '0;
      for (int k = 0; k < 8; k++) begin
        c = c + LANE_CNT_W'(x[k]);
      end
      return c;
    end
  endfunction

  // control store: one word per step, jump to target when cond holds, else fall through
  function automatic ucw_t ucode(input logic [UPC_W-1:0] upc);
    ucw_t w;
    begin
      w = '{take_in: 1'b0, mem_op: MEM_NONE, dp_op: DP_NONE, cond: C_NEVER,
            target: U_CLEAR};
      case (upc)
        U_CLEAR: begin
          w.mem_op = MEM_CLR;  w.dp_op = DP_CLRINC;
          w.cond = C_CLR_MORE; w.target = U_CLEAR;
        end
        U_IDLE: begin
          w.take_in = 1'b1;
          w.cond = C_NOT_ACC;  w.target = U_IDLE;
        end
        U_SETA: begin
          w.mem_op = MEM_SET_A; w.dp_op = DP_EDGE;
        end
        U_SETB: begin
          w.mem_op = MEM_SET_B;
          w.cond = C_NOT_LAST; w.target = U_IDLE;
        end
        U_START: begin
          w.dp_op = DP_I0;
          w.cond = C_N_ZERO;   w.target = U_IDLE;
        end
        U_ROWI: begin
          w.mem_op = MEM_RD_I; w.dp_op = DP_J0;
        end
        U_LATI:  w.dp_op = DP_LATI;
        U_ROWJ:  w.mem_op = MEM_RD_J;
        U_POP:   w.dp_op = DP_POP;
        U_SUM:   w.dp_op = DP_SUM;
        U_CMP: begin
          w.dp_op = DP_CMP;
          w.cond = C_J_MORE;   w.target = U_ROWJ;
        end
        U_EMIT: begin
          w.dp_op = DP_EMIT;
          w.cond = C_OUT_BUSY; w.target = U_EMIT;
        end
        U_NEXTI: begin
          w.dp_op = DP_NEXTI;
          w.cond = C_I_MORE;   w.target = U_ROWI;
        end
        U_FINISH: begin
          w.dp_op = DP_FINISH;
          w.cond = C_ALWAYS;   w.target = U_CLEAR;
        end
        default: begin
          w.cond = C_ALWAYS;   w.target = U_CLEAR;
        end
      endcase
      return w;
    end
  endfunction

endpackage

/* design/max_common_neighbor_suggest_unit.sv */
// Common-neighbour friend suggester: adjacency memory, microcoded sequencer and datapath.
//
// Input channel (in_valid / in_stall): one undirected edge per transaction, node ids
// in_node_a and in_node_b, with in_last_edge set on the final edge of a graph.
// Output channel (out_valid / out_stall): after the final edge, one transaction per
// node in id order giving how many non-adjacent nodes share the largest number of
// common neighbours with it, plus the node total; out_last_result marks the last.
// Sequencing, with n the node count of the graph:
//   - an edge occupies the sequencer for an accept step plus two bit writes, one
//     per memory row, since the adjacency memory has a single write port;
//   - the final edge then starts the scan over all pairs of rows: each pair
//     is read, popcounted in byte lanes, summed and compared over 4 steps;
//   - a clear pass over rows 0 to n-1 follows, one memory row per cycle, before
//     the next edge is taken.
// Reset clears the control state and starts a clear pass over all 64 rows of the
// adjacency memory; in_stall stays high until it is done.
// The result register frees the scan to run on while a result is held; a stall on
// the output only stops the sequencer when the next result is ready to be loaded.
module max_common_neighbor_suggest_unit
  import mcns_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ID_W-1:0]    in_node_a,
  input  logic [ID_W-1:0]    in_node_b,
  input  logic               in_last_edge,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ID_W-1:0]    out_node_index,
  output logic [SUG_W-1:0]   out_suggestion_count,
  output logic [TOTAL_W-1:0] out_node_total,
  output logic               out_last_result
);

  logic [MAX_NODES-1:0] adj_mem [MAX_NODES];

  logic [UPC_W-1:0]  upc_r, upc_nxt;
  ucw_t              cw;

  logic [ID_W-1:0]   a_r, a_nxt, b_r, b_nxt;
  logic              last_r, last_nxt;
  logic [CNT_W-1:0]  node_count_r, node_count_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [CNT_W-1:0]  clr_lim_r, clr_lim_nxt;
  logic [ADDR_W-1:0] i_r, i_nxt, j_r, j_nxt;

  logic [MAX_NODES-1:0] rd_data_r;
  logic [MAX_NODES-1:0] row_i_r, row_i_nxt;
  logic [LANES-1:0][LANE_CNT_W-1:0] part_r, part_nxt;
  logic              skip_r, skip_nxt;
  logic [CNT_W-1:0]  common_r, common_nxt;
  logic [CNT_W-1:0]  best_r, best_nxt;
  logic [CNT_W-1:0]  hits_r, hits_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]    out_index_r, out_index_nxt;
  logic [SUG_W-1:0]   out_count_r, out_count_nxt;
  logic [TOTAL_W-1:0] out_total_r, out_total_nxt;
  logic               out_last_r, out_last_nxt;

  logic              accept;
  logic              in_range;
  logic [ADDR_W-1:0] a_idx, b_idx;
  logic [CNT_W-1:0]  a_inc, b_inc;
  logic [CNT_W-1:0]  i_inc, j_inc, clr_inc;
  logic              i_more, j_more, clr_more, n_zero, out_free;
  logic              jump;
  logic [LANES*8-1:0] and_row;
  logic [CNT_W-1:0]  sum;

  assign cw       = ucode(upc_r);
  assign in_stall = !cw.take_in;
  assign accept   = in_valid && cw.take_in;

  assign in_range = ((ID_W+1)'(a_r) < (ID_W+1)'(MAX_NODES)) &&
                    ((ID_W+1)'(b_r) < (ID_W+1)'(MAX_NODES));
  assign a_idx    = a_r[ADDR_W-1:0];
  assign b_idx    = b_r[ADDR_W-1:0];
  assign a_inc    = CNT_W'(a_r) + CNT_W'(1);
  assign b_inc    = CNT_W'(b_r) + CNT_W'(1);

  assign i_inc    = CNT_W'(i_r) + CNT_W'(1);
  assign j_inc    = CNT_W'(j_r) + CNT_W'(1);
  assign clr_inc  = CNT_W'(clr_r) + CNT_W'(1);
  assign i_more   = i_inc < node_count_r;
  assign j_more   = j_inc < node_count_r;
  assign clr_more = clr_inc < clr_lim_r;
  assign n_zero   = node_count_r == '0;
  assign out_free = !out_valid_r || !out_stall;

  assign and_row  = (LANES*8)'(row_i_r & rd_data_r);

  always_comb begin
    sum = '0;
    for (int k = 0; k < LANES; k++) begin
      sum = sum + CNT_W'(part_r[k]);
    end
  end

  // sequencer
  always_comb begin
    case (cw.cond)
      C_ALWAYS:   jump = 1'b1;
      C_NOT_ACC:  jump = !in_valid;
      C_NOT_LAST: jump = !last_r;
      C_N_ZERO:   jump = n_zero;
      C_J_MORE:   jump = j_more;
      C_I_MORE:   jump = i_more;
      C_CLR_MORE: jump = clr_more;
      C_OUT_BUSY: jump = !out_free;
      default:    jump = 1'b0;
    endcase
    upc_nxt = jump ? cw.target : upc_r + UPC_W'(1);
  end

  // datapath
  always_comb begin
    a_nxt          = a_r;
    b_nxt          = b_r;
    last_nxt       = last_r;
    node_count_nxt = node_count_r;
    clr_nxt        = clr_r;
    clr_lim_nxt    = clr_lim_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    row_i_nxt      = row_i_r;
    part_nxt       = part_r;
    skip_nxt       = skip_r;
    common_nxt     = common_r;
    best_nxt       = best_r;
    hits_nxt       = hits_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_index_nxt  = out_index_r;
    out_count_nxt  = out_count_r;
    out_total_nxt  = out_total_r;
    out_last_nxt   = out_last_r;

    if (accept) begin
      a_nxt    = in_node_a;
      b_nxt    = in_node_b;
      last_nxt = in_last_edge;
    end

    case (cw.dp_op)
      DP_CLRINC: clr_nxt = clr_r + ADDR_W'(1);
      DP_EDGE: begin
        if (in_range) begin
          if (a_inc > node_count_nxt) node_count_nxt = a_inc;
          if (b_inc > node_count_nxt) node_count_nxt = b_inc;
        end
      end
      DP_I0:   i_nxt = '0;
      DP_J0: begin
        j_nxt    = '0;
        best_nxt = '0;
        hits_nxt = '0;
      end
      DP_LATI: row_i_nxt = rd_data_r;
      DP_POP: begin
        for (int k = 0; k < LANES; k++) begin
          part_nxt[k] = popcount8(and_row[k*8 +: 8]);
        end
        // the diagonal and direct neighbours are not candidates
        skip_nxt = (j_r == i_r) || row_i_r[j_r];
      end
      DP_SUM:  common_nxt = sum;
      DP_CMP: begin
        if (!skip_r) begin
          if (common_r > best_r) begin
            best_nxt = common_r;
            hits_nxt = CNT_W'(1);
          end else if (common_r == best_r) begin
            hits_nxt = hits_r + CNT_W'(1);
          end
        end
        j_nxt = j_r + ADDR_W'(1);
      end
      DP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = ID_W'(i_r);
          out_count_nxt = SUG_W'(hits_r);
          out_total_nxt = TOTAL_W'(node_count_r);
          out_last_nxt  = i_inc == node_count_r;
        end
      end
      DP_NEXTI: i_nxt = i_r + ADDR_W'(1);
      DP_FINISH: begin
        clr_nxt        = '0;
        clr_lim_nxt    = node_count_r;
        node_count_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r        <= U_CLEAR;
      node_count_r <= '0;
      clr_r        <= '0;
      clr_lim_r    <= CNT_W'(MAX_NODES);
      i_r          <= '0;
      j_r          <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      upc_r        <= upc_nxt;
      node_count_r <= node_count_nxt;
      clr_r        <= clr_nxt;
      clr_lim_r    <= clr_lim_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    last_r      <= last_nxt;
    row_i_r     <= row_i_nxt;
    part_r      <= part_nxt;
    skip_r      <= skip_nxt;
    common_r    <= common_nxt;
    best_r      <= best_nxt;
    hits_r      <= hits_nxt;
    out_index_r <= out_index_nxt;
    out_count_r <= out_count_nxt;
    out_total_r <= out_total_nxt;
    out_last_r  <= out_last_nxt;
  end

  // adjacency memory: single port, bit-set or row-clear writes, registered read
  always_ff @(posedge clk) begin
    case (cw.mem_op)
      MEM_RD_I:  rd_data_r <= adj_mem[i_r];
      MEM_RD_J:  rd_data_r <= adj_mem[j_r];
      MEM_SET_A: if (in_range) adj_mem[a_idx][b_idx] <= 1'b1;
      MEM_SET_B: if (in_range) adj_mem[b_idx][a_idx] <= 1'b1;
      MEM_CLR:   adj_mem[clr_r] <= '0;
      default: ;
    endcase
  end

  assign out_valid            = out_valid_r;
  assign out_node_index       = out_index_r;
  assign out_suggestion_count = out_count_r;
  assign out_node_total       = out_total_r;
  assign out_last_result      = out_last_r;

endmodule

/* design/mcns_chk.sv */
// Port-level checker for the common-neighbour suggester, bound to the top level.
module mcns_chk
  import mcns_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [ID_W-1:0]    in_node_a,
  input logic [ID_W-1:0]    in_node_b,
  input logic               in_last_edge,
  input logic               out_valid,
  input logic               out_stall,
  input logic [ID_W-1:0]    out_node_index,
  input logic [SUG_W-1:0]   out_suggestion_count,
  input logic [TOTAL_W-1:0] out_node_total,
  input logic               out_last_result
);

  // clear pass holds off edges straight after reset
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken during clear pass after reset");

  // each edge needs its two memory writes before the next transaction
  a_edge_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("edge accepted back to back");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (TOTAL_W'(out_node_index) < out_node_total))
    else $error("result node id beyond node total");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_result == ((TOTAL_W'(out_node_index) + TOTAL_W'(1))
                                       == out_node_total)))
    else $error("last flag disagrees with node id");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_node_index) &&
                               $stable(out_suggestion_count) && $stable(out_node_total))
    else $error("stalled result changed");

endmodule

bind max_common_neighbor_suggest_unit mcns_chk u_mcns_chk (.*);

/* test/suggestion_checker.sv */
`timescale 1ns / 1ps
// Checker for the suggester: mirrors the adjacency matrix and compares every node result.
module suggestion_checker
  import mcns_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [ID_W-1:0]    in_node_a,
  input  logic [ID_W-1:0]    in_node_b,
  input  logic               in_last_edge,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [ID_W-1:0]    out_node_index,
  input  logic [SUG_W-1:0]   out_suggestion_count,
  input  logic [TOTAL_W-1:0] out_node_total,
  input  logic               out_last_result,
  output int                 mismatches,
  output int                 results_due,
  output int                 results_checked
);

  typedef struct packed {
    logic [ID_W-1:0]    node;
    logic [SUG_W-1:0]   count;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } suggestion_t;

  logic [MAX_NODES-1:0] adj_rows [MAX_NODES];
  logic [TOTAL_W-1:0]   node_total;
  suggestion_t          suggestions_due [$];

  task automatic clear_graph();
    begin
      for (int k = 0; k < MAX_NODES; k++) adj_rows[k] = '0;
      node_total = '0;
    end
  endtask

  task automatic load_edge(input logic [ID_W-1:0] a, input logic [ID_W-1:0] b);
    begin
      adj_rows[a][b] = 1'b1;
      adj_rows[b][a] = 1'b1;
      if (int'(a) + 1 > int'(node_total)) node_total = TOTAL_W'(int'(a) + 1);
      if (int'(b) + 1 > int'(node_total)) node_total = TOTAL_W'(int'(b) + 1);
    end
  endtask

  // per node: count non-adjacent others reaching the best common-neighbour score
  task automatic queue_suggestions();
    int          best;
    int          hits;
    int          common;
    suggestion_t s;
    begin
      for (int i = 0; i < int'(node_total); i++) begin
        best = 0;
        hits = 0;
        for (int j = 0; j < int'(node_total); j++) begin
          if (j != i && !adj_rows[i][j]) begin
            common = $countones(adj_rows[i] & adj_rows[j]);
            if (common > best) begin
              best = common;
              hits = 1;
            end else if (common == best) begin
              hits++;
            end
          end
        end
        s.node  = ID_W'(i);
        s.count = SUG_W'(hits);
        s.total = node_total;
        s.last  = (i + 1 == int'(node_total));
        suggestions_due.insert(suggestions_due.size(), s);
      end
      clear_graph();
    end
  endtask

  always @(posedge clk) begin
    suggestion_t want;
    if (!rst_n) begin
      clear_graph();
      suggestions_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (suggestions_due.size() == 0) begin
          $error("unexpected result transaction for node %0d", out_node_index);
          mismatches++;
        end else begin
          want = suggestions_due.pop_front();
          results_checked++;
          if (out_node_index !== want.node) begin
            $error("node_index: expected %0d, got %0d", want.node, out_node_index);
            mismatches++;
          end
          if (out_suggestion_count !== want.count) begin
            $error("suggestion_count: expected %0d, got %0d", want.count,
                   out_suggestion_count);
            mismatches++;
          end
          if (out_node_total !== want.total) begin
            $error("node_total: expected %0d, got %0d", want.total, out_node_total);
            mismatches++;
          end
          if (out_last_result !== want.last) begin
            $error("last_result: expected %0d, got %0d", want.last, out_last_result);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        load_edge(in_node_a, in_node_b);
        if (in_last_edge) queue_suggestions();
      end
    end
    results_due = suggestions_due.size();
  end

endmodule

/* test/tb_max_common_neighbor_suggest_unit.sv */
`timescale 1ns / 1ps
// Testbench top for the suggester: edge stimulus, output back-pressure and the verdict.
module tb_max_common_neighbor_suggest_unit;
  import mcns_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [ID_W-1:0]    in_node_a;
  logic [ID_W-1:0]    in_node_b;
  logic               in_last_edge;
  logic               out_valid;
  logic               out_stall;
  logic [ID_W-1:0]    out_node_index;
  logic [SUG_W-1:0]   out_suggestion_count;
  logic [TOTAL_W-1:0] out_node_total;
  logic               out_last_result;

  int mismatches;
  int results_due;
  int results_checked;

  int edges_sent;
  int graphs_sent;
  int big_left;
  bit quiet_in;
  bit quiet_out;

  max_common_neighbor_suggest_unit u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_node_a            (in_node_a),
    .in_node_b            (in_node_b),
    .in_last_edge         (in_last_edge),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_node_index       (out_node_index),
    .out_suggestion_count (out_suggestion_count),
    .out_node_total       (out_node_total),
    .out_last_result      (out_last_result)
  );

  suggestion_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_node_a            (in_node_a),
    .in_node_b            (in_node_b),
    .in_last_edge         (in_last_edge),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_node_index       (out_node_index),
    .out_suggestion_count (out_suggestion_count),
    .out_node_total       (out_node_total),
    .out_last_result      (out_last_result),
    .mismatches           (mismatches),
    .results_due          (results_due),
    .results_checked      (results_checked)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_edge(input logic [ID_W-1:0] a, input logic [ID_W-1:0] b,
                           input logic last);
    int gap;
    begin
      gap = quiet_in ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid     <= 1'b1;
      in_node_a    <= a;
      in_node_b    <= b;
      in_last_edge <= last;
      do @(posedge clk); while (in_stall);
      @(negedge clk);
      edges_sent++;
    end
  endtask

  // one random graph; mostly small, occasionally up to the full id range
  task automatic send_graph();
    int r;
    int top_id;
    int n_edges;
    int a;
    int b;
    int pa;
    int pb;
    begin
      r = $urandom_range(0, 99);
      if (r >= 96 && big_left > 0) begin
        top_id = 63;
        big_left--;
      end else if (r >= 82) begin
        top_id = $urandom_range(16, 40);
      end else begin
        top_id = $urandom_range(1, 15);
      end
      n_edges   = $urandom_range(1, 24);
      quiet_in  = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      pa = 0;
      pb = 0;
      for (int k = 0; k < n_edges; k++) begin
        r = $urandom_range(0, 19);
        if (k > 0 && r < 3) begin
          // repeat of the previous edge, reversed
          a = pb;
          b = pa;
        end else if (r == 3) begin
          a = $urandom_range(0, top_id);
          b = a;
        end else begin
          a = $urandom_range(0, top_id);
          b = $urandom_range(0, top_id);
        end
        send_edge(ID_W'(a), ID_W'(b), k == n_edges - 1);
        pa = a;
        pb = b;
      end
      graphs_sent++;
    end
  endtask

  // result side back-pressure: fresh stall length drawn after each transaction
  initial begin
    int   stall_left;
    logic took;
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      took = out_valid && !out_stall;
      @(negedge clk);
      if (took) stall_left = quiet_out ? 0 : $urandom_range(0, 11);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_node_a    = '0;
    in_node_b    = '0;
    in_last_edge = 1'b0;
    edges_sent   = 0;
    graphs_sent  = 0;
    big_left     = 3;
    quiet_in     = 1'b0;
    quiet_out    = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single node with a self loop
    send_edge(0, 0, 1'b1);
    // self loop on the top id: 64 isolated nodes, each counting 63 others
    send_edge(63, 63, 1'b1);
    // triangle, nothing left to suggest
    send_edge(0, 1, 1'b0);
    send_edge(0, 2, 1'b0);
    send_edge(1, 2, 1'b1);
    // star with duplicate edges and a self loop
    send_edge(0, 1, 1'b0);
    send_edge(1, 0, 1'b0);
    send_edge(0, 2, 1'b0);
    send_edge(0, 3, 1'b0);
    send_edge(0, 1, 1'b0);
    send_edge(4, 4, 1'b0);
    send_edge(3, 5, 1'b1);
    // extreme and alternating id bit patterns
    send_edge(63, 0, 1'b0);
    send_edge(0, 63, 1'b0);
    send_edge(42, 21, 1'b0);
    send_edge(21, 42, 1'b0);
    send_edge(31, 32, 1'b0);
    send_edge(5, 5, 1'b1);
    // square plus isolated nodes: non-zero maximum beside zero-score nodes
    send_edge(0, 1, 1'b0);
    send_edge(1, 2, 1'b0);
    send_edge(2, 3, 1'b0);
    send_edge(3, 0, 1'b0);
    send_edge(6, 6, 1'b1);
    graphs_sent = 6;

    while (edges_sent < 298) send_graph();
    in_valid <= 1'b0;

    while (results_due != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("covered %0d graphs from %0d edge transactions, %0d node results checked",
             graphs_sent, edges_sent, results_checked);
    if (mismatches == 0 && results_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* max_common_neighbor_suggest_unit.f */
design/mcns_pkg.sv
design/max_common_neighbor_suggest_unit.sv
design/mcns_chk.sv
test/suggestion_checker.sv
test/tb_max_common_neighbor_suggest_unit.sv
